[design/pus_pkg.sv]
// Shared types and constants of the particle update pipeline.
// Used by every module of the block; depends on nothing.
package pus_pkg;

	// Fractional divider: one quotient bit per stage.
	localparam int DIV_BITS = 16;

	// Divide-by-fifteen unit: digits per stage, stages, operand width.
	localparam int D15_DIGITS = 8;
	localparam int D15_STAGES = 5;
	localparam int D15_W = D15_DIGITS * D15_STAGES;

	// Motion unit pipeline: two multiply stages, two divide-by-fifteen passes,
	// one product stage and one final add stage.
	localparam int MOT_LAT = 2 * D15_STAGES + 4;

	// Configuration port.
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [2:0] REG_START_COLOR = 3'd0;
	localparam logic [2:0] REG_MID_COLOR = 3'd1;
	localparam logic [2:0] REG_END_COLOR = 3'd2;
	localparam logic [2:0] REG_SIZE_POINTS = 3'd3;
	localparam logic [2:0] REG_LIFE_MID = 3'd4;
	localparam logic [2:0] REG_DECEL = 3'd5;
	localparam logic [2:0] REG_GRAVITY = 3'd6;

	localparam logic [31:0] START_COLOR_RST = 32'hFFB34CFF;
	localparam logic [31:0] MID_COLOR_RST = 32'hB3FF1AFF;
	localparam logic [31:0] END_COLOR_RST = 32'h4D33B3FF;
	localparam logic [59:0] SIZE_POINTS_RST = 60'd0;
	localparam logic [15:0] LIFE_MID_RST = 16'd32768;
	localparam logic [31:0] DECEL_RST = 32'd78643;
	localparam logic [47:0] GRAVITY_RST = 48'd0;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [31:0] speed_in;
		logic [31:0] born_ms;
		logic [15:0] life_ms;
		logic [31:0] now_ms;
		logic [15:0] step_scale;
	} part_t;

	typedef struct packed {
		logic expired;
		logic [31:0] color_out;
		logic [19:0] size_out;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic [31:0] speed_out;
	} upd_t;

	typedef struct packed {
		logic [2:0][31:0] new_pos;
		logic [31:0] speed;
	} mot_t;

endpackage

[design/particle_update_step.sv]
// Top level of the particle update pipeline with its register file.
// Depends on pus_pkg, pus_frac_div, pus_motion and pus_blend.
//
//   channel | valid      | stall      | payload | direction
//   --------+------------+------------+---------+----------
//   input   | part_valid | part_stall | part    | in
//   result  | upd_valid  | upd_stall  | upd     | out
//   config  | psel/penable/pwrite, pready high | pwdata  | in
//
// One particle enters per cycle unless the pipeline is stalled; each result
// passes the two 16-stage age and weight dividers in series.
// Speed and position run in a parallel 14-stage unit and are delayed to meet.
// A stalled result stops the whole pipeline; nothing moves and nothing is lost.
// Reset clears the valid bits and loads the register defaults.
module particle_update_step
	import pus_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	input  logic part_valid,
	output logic part_stall,
	input  part_t part,
	output logic upd_valid,
	input  logic upd_stall,
	output upd_t upd
);

	localparam int OUT_LAT = 2 * DIV_BITS + 4;
	localparam int MOT_DLY = OUT_LAT - MOT_LAT - 2;
	localparam int EXP_DLY = OUT_LAT - 3;

	// Register file.
	logic [31:0] start_color_q, mid_color_q, end_color_q, decel_q;
	logic [59:0] size_points_q;
	logic [15:0] life_mid_q;
	logic [47:0] gravity_q;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= START_COLOR_RST;
			mid_color_q <= MID_COLOR_RST;
			end_color_q <= END_COLOR_RST;
			size_points_q <= SIZE_POINTS_RST;
			life_mid_q <= LIFE_MID_RST;
			decel_q <= DECEL_RST;
			gravity_q <= GRAVITY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_START_COLOR: start_color_q <= pwdata[31:0];
				REG_MID_COLOR: mid_color_q <= pwdata[31:0];
				REG_END_COLOR: end_color_q <= pwdata[31:0];
				REG_SIZE_POINTS: size_points_q <= pwdata[59:0];
				REG_LIFE_MID: life_mid_q <= pwdata[15:0];
				REG_DECEL: decel_q <= pwdata[31:0];
				REG_GRAVITY: gravity_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_START_COLOR: prdata = PDATA_W'(start_color_q);
			REG_MID_COLOR: prdata = PDATA_W'(mid_color_q);
			REG_END_COLOR: prdata = PDATA_W'(end_color_q);
			REG_SIZE_POINTS: prdata = PDATA_W'(size_points_q);
			REG_LIFE_MID: prdata = PDATA_W'(life_mid_q);
			REG_DECEL: prdata = PDATA_W'(decel_q);
			REG_GRAVITY: prdata = PDATA_W'(gravity_q);
			default: prdata = '0;
		endcase
	end

	// Pipeline control: every stage advances unless a finished result waits.
	logic vld_q [OUT_LAT];
	logic en;

	assign part_stall = vld_q[OUT_LAT-1] & upd_stall;
	assign en = ~part_stall;
	assign upd_valid = vld_q[OUT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= part_valid;
			for (int k = 1; k < OUT_LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Input register and age stage.
	part_t part_s1;
	logic exp_s2, full_a_s2;
	logic [15:0] age_s2, life_s2;

	always_ff @(posedge clk) begin
		logic [31:0] age;
		if (en) begin
			part_s1 <= part;
			age = (part_s1.now_ms >= part_s1.born_ms) ?
				32'(part_s1.now_ms - part_s1.born_ms) : 32'd0;
			exp_s2 <= ({1'b0, part_s1.born_ms} + 33'(part_s1.life_ms))
				< {1'b0, part_s1.now_ms};
			full_a_s2 <= age >= {16'd0, part_s1.life_ms};
			age_s2 <= age[15:0];
			life_s2 <= part_s1.life_ms;
		end
	end

	// Age fraction divider.
	logic [DIV_BITS-1:0] qa;
	logic full_a_q [DIV_BITS];

	pus_frac_div u_div_age (
		.clk(clk), .en(en), .num(age_s2), .den({1'b0, life_s2}), .quo(qa)
	);

	// Segment select and weight divider setup.
	logic [15:0] n_s19;
	logic [16:0] d_s19;
	logic full_u_s19, seg_s19;

	always_ff @(posedge clk) begin
		logic [16:0] t;
		logic [16:0] m;
		logic [16:0] n;
		logic [16:0] d;
		if (en) begin
			t = full_a_q[DIV_BITS-1] ? ONE_Q16 : {1'b0, qa};
			m = {1'b0, life_mid_q};
			if (t <= m) begin
				n = t;
				d = m;
			end else begin
				n = 17'(t - m);
				d = 17'(ONE_Q16 - m);
			end
			n_s19 <= n[15:0];
			d_s19 <= d;
			full_u_s19 <= n >= d;
			seg_s19 <= t > m;
		end
	end

	logic [DIV_BITS-1:0] qb;
	logic full_u_q [DIV_BITS];
	logic seg_q [DIV_BITS];

	pus_frac_div u_div_wt (
		.clk(clk), .en(en), .num(n_s19), .den(d_s19), .quo(qb)
	);

	// Delay lines that keep side data in step with the dividers.
	logic exp_q [EXP_DLY];
	mot_t mot_q [MOT_DLY];
	mot_t mot;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				full_a_q[k] <= (k == 0) ? full_a_s2 : full_a_q[k == 0 ? 0 : k-1];
				full_u_q[k] <= (k == 0) ? full_u_s19 : full_u_q[k == 0 ? 0 : k-1];
				seg_q[k] <= (k == 0) ? seg_s19 : seg_q[k == 0 ? 0 : k-1];
			end
			for (int k = 0; k < EXP_DLY; k++) begin
				exp_q[k] <= (k == 0) ? exp_s2 : exp_q[k == 0 ? 0 : k-1];
			end
			for (int k = 0; k < MOT_DLY; k++) begin
				mot_q[k] <= (k == 0) ? mot : mot_q[k == 0 ? 0 : k-1];
			end
		end
	end

	pus_motion u_motion (
		.clk(clk), .en(en), .part(part_s1), .decel(decel_q),
		.gravity(gravity_q), .mot(mot)
	);

	// Blend and result register.
	logic seg;
	logic [16:0] u;
	logic [31:0] ca, cb, color;
	logic [19:0] sa, sb, size;

	assign seg = seg_q[DIV_BITS-1];
	assign u = full_u_q[DIV_BITS-1] ? ONE_Q16 : {1'b0, qb};
	assign ca = seg ? mid_color_q : start_color_q;
	assign cb = seg ? end_color_q : mid_color_q;
	assign sa = seg ? size_points_q[39:20] : size_points_q[59:40];
	assign sb = seg ? size_points_q[19:0] : size_points_q[39:20];

	pus_blend u_blend (
		.ca(ca), .cb(cb), .sa(sa), .sb(sb), .u(u), .color(color), .size(size)
	);

	always_ff @(posedge clk) begin
		mot_t mt;
		upd_t r;
		if (en) begin
			mt = mot_q[MOT_DLY-1];
			r = '0;
			if (exp_q[EXP_DLY-1]) begin
				r.expired = 1'b1;
			end else begin
				r.color_out = color;
				r.size_out = size;
				r.new_pos_x = mt.new_pos[0];
				r.new_pos_y = mt.new_pos[1];
				r.new_pos_z = mt.new_pos[2];
				r.speed_out = mt.speed;
			end
			upd <= r;
		end
	end

endmodule

[design/pus_frac_div.sv]
// Pipelined fractional divider: quo = (num << 16) / den for num < den.
// Depends on pus_pkg.
module pus_frac_div
	import pus_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic [15:0] num,
	input  logic [16:0] den,
	output logic [DIV_BITS-1:0] quo
);

	logic [16:0] rem_s [DIV_BITS];
	logic [16:0] den_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	logic [16:0] rem_n [DIV_BITS];
	logic [DIV_BITS-1:0] quo_n [DIV_BITS];

	always_comb begin
		logic [16:0] r_prev;
		logic [16:0] d_prev;
		logic [DIV_BITS-1:0] q_prev;
		logic [17:0] r2;
		logic ge;
		for (int k = 0; k < DIV_BITS; k++) begin
			if (k == 0) begin
				r_prev = {1'b0, num};
				d_prev = den;
				q_prev = '0;
			end else begin
				r_prev = rem_s[k-1];
				d_prev = den_s[k-1];
				q_prev = quo_s[k-1];
			end
			r2 = {r_prev, 1'b0};
			ge = r2 >= {1'b0, d_prev};
			rem_n[k] = ge ? 17'(r2 - {1'b0, d_prev}) : r2[16:0];
			quo_n[k] = {q_prev[DIV_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
				den_s[k] <= (k == 0) ? den : den_s[k == 0 ? 0 : k-1];
			end
		end
	end

	assign quo = quo_s[DIV_BITS-1];

endmodule

[design/pus_div15.sv]
// Pipelined division by fifteen, eight quotient digits per stage.
// Depends on pus_pkg.
module pus_div15
	import pus_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic [D15_W-1:0] x,
	output logic [D15_W-1:0] q
);

	logic [3:0] rem_s [D15_STAGES];
	logic [D15_W-1:0] x_s [D15_STAGES];
	logic [D15_W-1:0] q_s [D15_STAGES];
	logic [3:0] rem_n [D15_STAGES];
	logic [D15_W-1:0] q_n [D15_STAGES];

	always_comb begin
		logic [3:0] r;
		logic [4:0] r5;
		logic [D15_W-1:0] xv;
		logic [D15_W-1:0] qv;
		logic [D15_DIGITS-1:0] bits;
		for (int k = 0; k < D15_STAGES; k++) begin
			if (k == 0) begin
				r = '0;
				xv = x;
				qv = '0;
			end else begin
				r = rem_s[k-1];
				xv = x_s[k-1];
				qv = q_s[k-1];
			end
			for (int b = 0; b < D15_DIGITS; b++) begin
				r5 = {r, xv[D15_W-1-k*D15_DIGITS-b]};
				bits[D15_DIGITS-1-b] = r5 >= 5'd15;
				r = bits[D15_DIGITS-1-b] ? 4'(r5 - 5'd15) : r5[3:0];
			end
			rem_n[k] = r;
			q_n[k] = {qv[D15_W-D15_DIGITS-1:0], bits};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < D15_STAGES; k++) begin
				rem_s[k] <= rem_n[k];
				q_s[k] <= q_n[k];
				x_s[k] <= (k == 0) ? x : x_s[k == 0 ? 0 : k-1];
			end
		end
	end

	assign q = q_s[D15_STAGES-1];

endmodule

[design/pus_motion.sv]
// Speed and position update: deceleration, speed step, gravity step.
// Depends on pus_pkg and pus_div15.
module pus_motion
	import pus_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  part_t part,
	input  logic [31:0] decel,
	input  logic [47:0] gravity,
	output mot_t mot
);

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][15:0] dir;
		logic [31:0] speed;
		logic [15:0] step;
		logic [2:0] gneg;
	} side_a_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][15:0] dir;
		logic [31:0] spd;
		logic [2:0][31:0] dg;
	} side_b_t;

	typedef struct packed {
		logic [2:0][51:0] dvp;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] dg;
		logic [31:0] spd;
	} side_c_t;

	// First multiply stage.
	side_a_t a_n;
	side_a_t a_s1;
	side_a_t a_q [D15_STAGES];
	logic [D15_W-1:0] xdec_n, xdec_s1;
	logic [D15_W-1:0] xg_n [3];
	logic [D15_W-1:0] xg_s1 [3];
	logic [D15_W-1:0] qdec;
	logic [D15_W-1:0] qg [3];

	always_comb begin
		logic [47:0] dec_p;
		logic [15:0] gv;
		logic signed [32:0] gp;
		logic [31:0] gmag;
		a_n.pos = {part.pos_z, part.pos_y, part.pos_x};
		a_n.dir = {part.dir_z, part.dir_y, part.dir_x};
		a_n.speed = part.speed_in;
		a_n.step = part.step_scale;
		dec_p = 48'(decel) * 48'(part.step_scale);
		xdec_n = D15_W'(dec_p >> 10);
		for (int k = 0; k < 3; k++) begin
			gv = gravity[47-16*k -: 16];
			gp = $signed({{17{gv[15]}}, gv}) * $signed({17'd0, part.step_scale});
			a_n.gneg[k] = gp[32];
			gmag = gp[32] ? 32'(-gp) : 32'(gp);
			xg_n[k] = D15_W'(gmag >> 2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_n;
			xdec_s1 <= xdec_n;
			for (int k = 0; k < 3; k++) begin
				xg_s1[k] <= xg_n[k];
			end
			for (int k = 0; k < D15_STAGES; k++) begin
				a_q[k] <= (k == 0) ? a_s1 : a_q[k == 0 ? 0 : k-1];
			end
		end
	end

	pus_div15 u_div_dec (.clk(clk), .en(en), .x(xdec_s1), .q(qdec));

	for (genvar g = 0; g < 3; g++) begin : g_grav
		pus_div15 u_div_g (.clk(clk), .en(en), .x(xg_s1[g]), .q(qg[g]));
	end

	// Speed clamp and second multiply stage.
	side_b_t b_n;
	side_b_t b_s2;
	side_b_t b_q [D15_STAGES];
	logic [D15_W-1:0] xsf_n, xsf_s2;
	logic [D15_W-1:0] qsf;

	always_comb begin
		side_a_t a;
		logic [47:0] sp_p;
		a = a_q[D15_STAGES-1];
		b_n.pos = a.pos;
		b_n.dir = a.dir;
		b_n.spd = ({8'd0, a.speed} > qdec) ? 32'(a.speed - qdec[31:0]) : 32'd0;
		for (int k = 0; k < 3; k++) begin
			b_n.dg[k] = a.gneg[k] ? 32'(-qg[k][31:0]) : qg[k][31:0];
		end
		sp_p = 48'(b_n.spd) * 48'(a.step);
		xsf_n = D15_W'(sp_p >> 10);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2 <= b_n;
			xsf_s2 <= xsf_n;
			for (int k = 0; k < D15_STAGES; k++) begin
				b_q[k] <= (k == 0) ? b_s2 : b_q[k == 0 ? 0 : k-1];
			end
		end
	end

	pus_div15 u_div_sf (.clk(clk), .en(en), .x(xsf_s2), .q(qsf));

	// Direction times speed step.
	side_c_t c_n;
	side_c_t c_s3;

	always_comb begin
		side_b_t b;
		b = b_q[D15_STAGES-1];
		c_n.pos = b.pos;
		c_n.dg = b.dg;
		c_n.spd = b.spd;
		for (int k = 0; k < 3; k++) begin
			c_n.dvp[k] = 52'($signed({{36{b.dir[k][15]}}, b.dir[k]})
				* $signed({17'd0, qsf[34:0]}));
		end
	end

	// Final add; the shift rounds toward zero.
	mot_t m_n;

	always_comb begin
		logic signed [51:0] p;
		logic signed [51:0] adj;
		logic signed [51:0] dv;
		m_n.speed = c_s3.spd;
		for (int k = 0; k < 3; k++) begin
			p = c_s3.dvp[k];
			adj = p[51] ? p + 52'sd16383 : p;
			dv = adj >>> 14;
			m_n.new_pos[k] = c_s3.pos[k] + dv[31:0] + c_s3.dg[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= c_n;
			mot <= m_n;
		end
	end

endmodule

[design/pus_blend.sv]
// Colour and size blend between two key points with a Q1.16 weight.
// Depends on pus_pkg.
module pus_blend
	import pus_pkg::*;
(
	input  logic [31:0] ca,
	input  logic [31:0] cb,
	input  logic [19:0] sa,
	input  logic [19:0] sb,
	input  logic [16:0] u,
	output logic [31:0] color,
	output logic [19:0] size
);

	// Rounds half up.
	function automatic logic [9:0] mix(input logic [9:0] a, input logic [9:0] b,
			input logic [16:0] w);
		logic [27:0] sum;
		sum = 28'(a) * 28'(ONE_Q16 - w) + 28'(b) * 28'(w) + 28'd32768;
		return sum[25:16];
	endfunction

	always_comb begin
		logic [9:0] r;
		for (int k = 0; k < 4; k++) begin
			r = mix({2'b00, ca[8*k +: 8]}, {2'b00, cb[8*k +: 8]}, u);
			color[8*k +: 8] = r[7:0];
		end
		for (int k = 0; k < 2; k++) begin
			size[10*k +: 10] = mix(sa[10*k +: 10], sb[10*k +: 10], u);
		end
	end

endmodule
